// ===== design/fcf_pkg.sv =====
package fcf_pkg;

  // Widths of the fixed register and input fields.
  localparam int DELAY_W    = 17;
  localparam int GAIN_W     = 16;
  localparam int GAIN_FRAC  = 15;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 17;

  // Register indexes on the configuration port.
  localparam logic [CFG_ADDR_W-1:0] REG_GAIN          = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_DEFAULT_DELAY = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_ACTIVE_LENGTH = 2'd2;

  // Reset values of the registers.
  localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd0;
  localparam logic [DELAY_W-1:0] DELAY_RESET = 17'd1;
  localparam logic [DELAY_W-1:0] LENGTH_RESET = 17'd0;

  // The feedback gain is held within about plus or minus 0.999.
  localparam logic signed [GAIN_W-1:0] GAIN_MAX = 16'sd32735;
  localparam logic signed [GAIN_W-1:0] GAIN_MIN = -16'sd32735;

endpackage

// ===== design/fcf_ram.sv =====
module fcf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/feedback_comb_filter.sv =====
// Feedback comb filter: y = sat(x + ((g * line[wp - D]) >>> 15)), with y
// written back into a circular delay line that wraps at the active length.
// Input words arrive on in_tvalid/in_tready; in_tdata carries the sample and
// the per-sample delay, in_tuser selects that delay or the default_delay
// register. Results leave on out_tvalid/out_tready from an output register.
// The user is to write registers on the cfg_ port only while the filter is
// idle; the block itself does not enforce this. An accepted word moves
// through stages s1, s2 and s3 to the output register. Throughput: one word
// per cycle while no hazard or stall holds it. The delay line is a single
// RAM with one write and one registered read port, read as a word moves from
// s1 to s2 and written as it moves from s3 to the output; a word whose read
// address is still to be written by one of the two words ahead waits, which
// slows delays of one or two (likewise for very short active lengths).
// After a write to active_length the write position is reduced modulo the
// new length by a bit-serial unit; in_tready is low while that unit runs.
// Reset empties the pipeline and sets the registers to their defaults. The
// delay line is not swept: a fill mark makes never-written entries read as
// zero, so words are accepted in the first cycle after reset.
// When the receiver stalls, the result is held and the pipeline keeps
// accepting words until its stages are full.
module feedback_comb_filter #(
  parameter int LINE_DEPTH  = 65536,
  parameter int SAMPLE_BITS = 24,
  localparam int IN_DATA_W  = ((SAMPLE_BITS + fcf_pkg::DELAY_W + 7) / 8) * 8,
  localparam int OUT_DATA_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata: sample_in, delay_in
  input  logic [IN_DATA_W-1:0]            in_tdata,
  // in_tuser: use_delay_in
  input  logic [0:0]                      in_tuser,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // out_tdata: sample_out
  output logic [OUT_DATA_W-1:0]           out_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic                            cfg_we,
  input  logic [fcf_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [fcf_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import fcf_pkg::*;

  localparam int SB     = SAMPLE_BITS;
  localparam int AW     = $clog2(LINE_DEPTH);
  localparam int LW     = $clog2(LINE_DEPTH + 1);
  localparam int CW     = (LW > DELAY_W) ? LW : DELAY_W;
  localparam int PW     = SB + GAIN_W;
  localparam int CNT_W  = $clog2(AW + 1);

  // Configuration registers.
  logic [GAIN_W-1:0]  gain_r;
  logic [DELAY_W-1:0] default_delay_r;
  logic [DELAY_W-1:0] active_length_r;

  // Write position and fill mark.
  logic [AW-1:0] wp_r;
  logic [AW-1:0] wp_nxt;
  logic [CW-1:0] fill_r;

  // Bit-serial modulo unit.
  logic             mod_busy_r;
  logic [CNT_W-1:0] mod_cnt_r;
  logic [CW-1:0]    mod_rem_r;
  logic [AW-1:0]    mod_q_r;
  logic [CW:0]      mod_try;
  logic [CW:0]      mod_step;

  // Pipeline stages.
  logic                 s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic                 s1_v_nxt, s2_v_nxt, s3_v_nxt, out_v_nxt;
  logic signed [SB-1:0] s1_x_r, s2_x_r, s3_x_r;
  logic [AW-1:0]        s1_wp_r, s2_wp_r, s3_wp_r;
  logic [CW-1:0]        s1_dly_r;
  logic                 s2_hit_r;
  logic signed [PW-1:0] s3_prod_r;
  logic [SB-1:0]        out_data_r;

  logic          accept;
  logic          adv1, adv2, adv3;
  logic          en1, en2, en3;
  logic          hazard;
  logic [CW-1:0] cap;
  logic [CW-1:0] act_ext;
  logic [CW-1:0] dsel;
  logic [CW-1:0] dly;
  logic [CW:0]   rp_diff;
  logic [CW:0]   rp_wrap;
  logic [AW-1:0] rp;
  logic          rp_hit;

  logic signed [GAIN_W-1:0] gain_c;
  logic signed [SB-1:0]     line_d;
  logic signed [PW-1:0]     prod;
  logic [SB-1:0]            ram_rd;
  logic signed [PW-1:0]     fb;
  logic signed [SB+1:0]     sum;
  logic [SB-1:0]            y;

  // Length in use: zero or anything above the depth selects the full depth.
  always_comb begin
    act_ext = CW'(active_length_r);
    if (act_ext == '0 || act_ext > CW'(LINE_DEPTH)) begin
      cap = CW'(LINE_DEPTH);
    end else begin
      cap = act_ext;
    end
  end

  // Delay selection and clamping to 1..length.
  always_comb begin
    if (in_tuser[0]) begin
      dsel = CW'(in_tdata[SB +: DELAY_W]);
    end else begin
      dsel = CW'(default_delay_r);
    end
    if (dsel == '0) begin
      dly = CW'(1);
    end else if (dsel > cap) begin
      dly = cap;
    end else begin
      dly = dsel;
    end
  end

  always_comb begin
    if (CW'(wp_r) + CW'(1) == cap) begin
      wp_nxt = '0;
    end else begin
      wp_nxt = wp_r + AW'(1);
    end
  end

  // Read address: wp - delay, wrapped by the length when it goes negative.
  always_comb begin
    rp_diff = {1'b0, CW'(s1_wp_r)} - {1'b0, s1_dly_r};
    rp_wrap = {1'b0, CW'(s1_wp_r)} + {1'b0, cap} - {1'b0, s1_dly_r};
    if (rp_diff[CW]) begin
      rp = AW'(rp_wrap);
    end else begin
      rp = AW'(rp_diff);
    end
    rp_hit = CW'(rp) < fill_r;
    hazard = (s2_v_r && s2_wp_r == rp) || (s3_v_r && s3_wp_r == rp);
  end

  // Stage handshakes: a stage moves on when the one after it has room (s1 also waits on a read hazard).
  always_comb begin
    en3 = !s3_v_r || !out_v_r || out_tready;
    adv3 = s3_v_r && en3;
    en2 = !s2_v_r || en3;
    adv2 = s2_v_r && en3;
    adv1 = s1_v_r && en2 && !hazard;
    en1 = !s1_v_r || adv1;
    in_tready = en1 && !mod_busy_r;
    accept = in_tvalid && in_tready;

    s1_v_nxt = accept ? 1'b1 : (adv1 ? 1'b0 : s1_v_r);
    s2_v_nxt = adv1 ? 1'b1 : (adv2 ? 1'b0 : s2_v_r);
    s3_v_nxt = adv2 ? 1'b1 : (adv3 ? 1'b0 : s3_v_r);
    out_v_nxt = adv3 ? 1'b1 : (out_tready ? 1'b0 : out_v_r);
  end

  // Feedback product.
  always_comb begin
    if ($signed(gain_r) > GAIN_MAX) begin
      gain_c = GAIN_MAX;
    end else if ($signed(gain_r) < GAIN_MIN) begin
      gain_c = GAIN_MIN;
    end else begin
      gain_c = $signed(gain_r);
    end
    line_d = s2_hit_r ? $signed(ram_rd) : '0;
    prod = PW'(gain_c) * PW'(line_d);
  end

  // Scale, add and saturate.
  always_comb begin
    fb = s3_prod_r >>> GAIN_FRAC;
    sum = (SB + 2)'(s3_x_r) + (SB + 2)'(fb);
    if (sum[SB+1:SB-1] == '0 || sum[SB+1:SB-1] == '1) begin
      y = sum[SB-1:0];
    end else begin
      y = {sum[SB+1], {(SB - 1){~sum[SB+1]}}};
    end
  end

  // One restoring step of wp mod length.
  always_comb begin
    mod_try = {mod_rem_r, mod_q_r[AW-1]};
    if (mod_try >= {1'b0, cap}) begin
      mod_step = mod_try - {1'b0, cap};
    end else begin
      mod_step = mod_try;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r          <= GAIN_RESET;
      default_delay_r <= DELAY_RESET;
      active_length_r <= LENGTH_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_GAIN:          gain_r <= cfg_wdata[GAIN_W-1:0];
        REG_DEFAULT_DELAY: default_delay_r <= cfg_wdata[DELAY_W-1:0];
        REG_ACTIVE_LENGTH: active_length_r <= cfg_wdata[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_busy_r <= 1'b0;
      mod_cnt_r  <= '0;
      wp_r       <= '0;
    end else if (cfg_we && cfg_addr == REG_ACTIVE_LENGTH) begin
      mod_busy_r <= 1'b1;
      mod_cnt_r  <= CNT_W'(AW);
      mod_rem_r  <= '0;
      mod_q_r    <= wp_r;
    end else if (mod_busy_r) begin
      mod_rem_r <= CW'(mod_step);
      mod_q_r   <= mod_q_r << 1;
      mod_cnt_r <= mod_cnt_r - CNT_W'(1);
      if (mod_cnt_r == CNT_W'(1)) begin
        mod_busy_r <= 1'b0;
        wp_r       <= AW'(mod_step);
      end
    end else if (accept) begin
      wp_r <= wp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      fill_r  <= '0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      s2_v_r  <= s2_v_nxt;
      s3_v_r  <= s3_v_nxt;
      out_v_r <= out_v_nxt;
      // Writes never land beyond the fill mark, so everything below it has
      // been written at least once since reset.
      if (adv3 && CW'(s3_wp_r) == fill_r) begin
        fill_r <= fill_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_x_r   <= $signed(in_tdata[SB-1:0]);
      s1_wp_r  <= wp_r;
      s1_dly_r <= dly;
    end
    if (adv1) begin
      s2_x_r   <= s1_x_r;
      s2_wp_r  <= s1_wp_r;
      s2_hit_r <= rp_hit;
    end
    if (adv2) begin
      s3_x_r    <= s2_x_r;
      s3_wp_r   <= s2_wp_r;
      s3_prod_r <= prod;
    end
    if (adv3) begin
      out_data_r <= y;
    end
  end

  fcf_ram #(
    .WIDTH(SB),
    .DEPTH(LINE_DEPTH)
  ) u_line (
    .clk  (clk),
    .we   (adv3),
    .waddr(s3_wp_r),
    .wdata(y),
    .re   (adv1),
    .raddr(rp),
    .rdata(ram_rd)
  );

  assign out_tvalid = out_v_r;
  assign out_tdata  = OUT_DATA_W'(out_data_r);

endmodule

// ===== design/fcf_checker.sv =====
module fcf_checker #(
  parameter int SAMPLE_BITS = 24,
  localparam int OUT_DATA_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [OUT_DATA_W-1:0]           out_tdata,
  input logic                            cfg_we,
  input logic [fcf_pkg::CFG_ADDR_W-1:0]  cfg_addr
);
  import fcf_pkg::*;

  // Reset empties the pipeline and leaves the input side open.
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("pipeline not empty or input closed after reset");

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed or dropped while stalled");

  // A new length closes the input while the write position is reduced.
  a_len_interlock: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && cfg_addr == REG_ACTIVE_LENGTH |=> !in_tready)
    else $error("input open while the write position is being reduced");

endmodule

bind feedback_comb_filter fcf_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_fcf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .cfg_we    (cfg_we),
  .cfg_addr  (cfg_addr)
);

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import fcf_pkg::*;

  localparam int DEPTH      = 65536;
  localparam int DEPTH_AW   = $clog2(DEPTH);
  localparam int SMP_W      = 24;
  localparam int IN_W       = ((SMP_W + DELAY_W + 7) / 8) * 8;
  localparam int OUT_W      = ((SMP_W + 7) / 8) * 8;
  localparam int PIPE_PAD   = 8;
  localparam int LONG_HOLD  = 300;
  localparam int CYCLE_CAP  = 200000;
  localparam int N_PHASES   = 14;
  localparam int PHASE_LEN  = 96;
  localparam logic signed [SMP_W-1:0] SMP_MAX = 24'sh7FFFFF;
  localparam logic signed [SMP_W-1:0] SMP_MIN = 24'sh800000;

  typedef struct packed {
    logic                     use_dly;
    logic [DELAY_W-1:0]       dly;
    logic signed [SMP_W-1:0]  smp;
  } word_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic [IN_W-1:0]        in_tdata;
  logic [0:0]             in_tuser;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [OUT_W-1:0]       out_tdata;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  // Our own copy of the filter state and its registers.
  logic signed [SMP_W-1:0] echo_line [0:DEPTH-1];
  int unsigned             wr_pos;
  logic [GAIN_W-1:0]       gain_reg;
  logic [DELAY_W-1:0]      dflt_reg;
  logic [DELAY_W-1:0]      len_reg;

  word_t                   pending_words[$];
  logic [SMP_W-1:0]        expected_out[$];
  word_t                   held_word = '0;
  int                      idle_pct = 10;
  int                      hold_requests = 0;
  int                      holds_taken = 0;
  int                      hold_left = 0;
  int                      error_count = 0;
  int                      results_seen = 0;
  int                      cycles = 0;

  assign in_tdata = {{(IN_W - SMP_W - DELAY_W){1'b0}}, held_word.dly, held_word.smp};
  assign in_tuser = held_word.use_dly;

  feedback_comb_filter DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned line_cap();
    int unsigned c;
    c = 32'(len_reg);
    if (c == 0 || c > DEPTH)
      c = DEPTH;
    return c;
  endfunction

  // One step of the filter: read the tap, feed it back, store and advance.
  function automatic logic [SMP_W-1:0] filter_sample(word_t w);
    int unsigned c;
    int unsigned wp;
    int unsigned rp;
    int unsigned d;
    longint g;
    longint y;
    c = line_cap();
    wp = wr_pos % c;
    g = longint'($signed(gain_reg));
    if (g > GAIN_MAX)
      g = longint'(GAIN_MAX);
    if (g < GAIN_MIN)
      g = longint'(GAIN_MIN);
    d = w.use_dly ? int'(w.dly) : int'(dflt_reg);
    if (d < 1)
      d = 1;
    if (d > c)
      d = c;
    rp = (wp + c - d) % c;
    y = longint'(w.smp)
        + ((g * longint'(echo_line[rp[DEPTH_AW-1:0]])) >>> GAIN_FRAC);
    if (y > longint'(SMP_MAX))
      y = longint'(SMP_MAX);
    if (y < longint'(SMP_MIN))
      y = longint'(SMP_MIN);
    echo_line[wp[DEPTH_AW-1:0]] = y[SMP_W-1:0];
    wr_pos = (wp + 1 == c) ? 0 : wp + 1;
    return y[SMP_W-1:0];
  endfunction

  // Driver: offers queued words, records a prediction for each accepted one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        expected_out.push_back(filter_sample(held_word));
      if (!in_tvalid || in_tready) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
          held_word <= pending_words.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result word against the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_out.size() == 0) begin
          error_count <= error_count + 1;
          if (error_count < 10)
            $display("unexpected result word %06h", out_tdata[SMP_W-1:0]);
        end else begin
          if (expected_out[0] !== out_tdata[SMP_W-1:0]) begin
            error_count <= error_count + 1;
            if (error_count < 10)
              $display("result %0d: sample_out expected %06h, got %06h",
                       results_seen, expected_out[0], out_tdata[SMP_W-1:0]);
          end
          void'(expected_out.pop_front());
        end
        results_seen <= results_seen + 1;
      end
      if (hold_left != 0) begin
        out_tready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (hold_requests != holds_taken) begin
        holds_taken <= holds_taken + 1;
        hold_left <= LONG_HOLD;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                           input int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val[CFG_DATA_W-1:0];
    case (idx)
      REG_GAIN:          gain_reg = val[GAIN_W-1:0];
      REG_DEFAULT_DELAY: dflt_reg = val[DELAY_W-1:0];
      REG_ACTIVE_LENGTH: len_reg = val[DELAY_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_word(input logic signed [SMP_W-1:0] s, input int unsigned d,
                           input logic u);
    word_t w;
    w.smp = s;
    w.dly = d[DELAY_W-1:0];
    w.use_dly = u;
    pending_words.push_back(w);
  endtask

  // The sender pauses here until every predicted word has come back.
  task automatic wait_drained();
    while (pending_words.size() != 0 || in_tvalid || expected_out.size() != 0)
      @(posedge clk);
    repeat (PIPE_PAD) @(posedge clk);
  endtask

  initial begin
    int unsigned c;
    int unsigned d;
    logic signed [SMP_W-1:0] s;
    for (int i = 0; i < DEPTH; i++)
      echo_line[i[DEPTH_AW-1:0]] = '0;
    wr_pos = 0;
    gain_reg = GAIN_RESET;
    dflt_reg = DELAY_RESET;
    len_reg = LENGTH_RESET;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: full depth, so every tap still reads zero.
    push_word(SMP_MAX, 0, 1'b1);
    push_word(SMP_MIN, 65536, 1'b1);
    push_word(SMP_W'(0), 131071, 1'b1);
    push_word(SMP_W'(-1), 0, 1'b0);
    wait_drained();

    // Largest positive gain on a short line drives the sum into saturation,
    // and a zero default delay must behave as a delay of one.
    write_reg(REG_GAIN, int'(GAIN_MAX));
    write_reg(REG_ACTIVE_LENGTH, 4);
    write_reg(REG_DEFAULT_DELAY, 0);
    push_word(SMP_MAX, 0, 1'b0);
    push_word(SMP_MAX, 0, 1'b0);
    push_word(SMP_MAX, 0, 1'b0);
    push_word(SMP_MIN, 1, 1'b1);
    push_word(SMP_MIN, 1, 1'b1);
    push_word(SMP_MIN, 200, 1'b1);
    push_word(SMP_W'(0), 0, 1'b1);
    push_word(SMP_W'(0), 4, 1'b1);
    wait_drained();

    // Gain below the limit is clamped; length above the depth means full depth.
    write_reg(REG_GAIN, 'h08000);
    write_reg(REG_ACTIVE_LENGTH, 131071);
    write_reg(REG_DEFAULT_DELAY, 65536);
    push_word(SMP_MAX, 0, 1'b0);
    push_word(SMP_MAX, 1, 1'b1);
    push_word(SMP_MAX, 1, 1'b1);
    push_word(SMP_MIN, 2, 1'b1);
    push_word(SMP_W'(12345), 65536, 1'b1);
    push_word(SMP_W'(-1), 3, 1'b1);
    wait_drained();

    // Gain above the limit, and a line of a single entry.
    write_reg(REG_GAIN, 'h17FFF);
    write_reg(REG_ACTIVE_LENGTH, 1);
    push_word(SMP_MAX, 5, 1'b1);
    push_word(SMP_MAX, 0, 1'b0);
    push_word(SMP_MIN, 0, 1'b0);
    wait_drained();

    for (int p = 0; p < N_PHASES; p++) begin
      idle_pct = (p == 5 || p == 6) ? 0 : 10;
      // Registers left alone keep their value, so the length often changes
      // while the write position carries on from the last phase.
      if (p == 0 || $urandom_range(2) != 0) begin
        case ($urandom_range(5))
          0: write_reg(REG_GAIN, int'(GAIN_MAX));
          1: write_reg(REG_GAIN, int'(GAIN_MIN));
          2: write_reg(REG_GAIN, 'h08000);
          3: write_reg(REG_GAIN, 'h07FFF);
          default: write_reg(REG_GAIN, $urandom);
        endcase
      end
      if (p == 0 || $urandom_range(2) != 0) begin
        case ($urandom_range(7))
          0: write_reg(REG_ACTIVE_LENGTH, 0);
          1: write_reg(REG_ACTIVE_LENGTH, 1);
          2: write_reg(REG_ACTIVE_LENGTH, 2);
          3: write_reg(REG_ACTIVE_LENGTH, 65536);
          4: write_reg(REG_ACTIVE_LENGTH, $urandom);
          default: write_reg(REG_ACTIVE_LENGTH, $urandom_range(3, 96));
        endcase
      end
      c = line_cap();
      if (p == 0 || $urandom_range(2) != 0) begin
        case ($urandom_range(3))
          0: write_reg(REG_DEFAULT_DELAY, $urandom);
          1: write_reg(REG_DEFAULT_DELAY, 0);
          default: write_reg(REG_DEFAULT_DELAY, $urandom_range(1, (c > 128) ? 128 : c));
        endcase
      end
      for (int i = 0; i < PHASE_LEN; i++) begin
        case ($urandom_range(15))
          0: s = SMP_MAX;
          1: s = SMP_MIN;
          default: s = SMP_W'($urandom);
        endcase
        if ($urandom_range(3) == 0)
          d = $urandom_range(0, 131071);
        else
          d = $urandom_range(1, (c > 128) ? 128 : c);
        push_word(s, d, 1'($urandom_range(1)));
      end
      // Hold the result side off while words keep coming, so the input stalls.
      if (p == 3 || p == 9)
        hold_requests = hold_requests + 1;
      wait_drained();
    end

    if (error_count == 0 && expected_out.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
